>>> hw/rtl/ihpq_pkg.sv
// ----------------------------------------------------------------------------
// ihpq_pkg
// Shared types and constants for the interval heap priority queue unit.
// ----------------------------------------------------------------------------
package ihpq_pkg;

	localparam int KEY_W = 32;
	localparam int CAP   = 1024;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_POP_MIN = 3'd1;
	localparam logic [2:0] OP_POP_MAX = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_PEEK    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] popped_key;
		logic [KEY_W-1:0] min_key;
		logic [KEY_W-1:0] max_key;
		logic [CNT_W-1:0] entry_count;
		logic [1:0]       status;
	} rsp_t;

endpackage

>>> hw/rtl/ihpq_ram.sv
// ----------------------------------------------------------------------------
// ihpq_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ihpq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/interval_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// interval_heap_priority_queue_unit
// Double-ended priority queue kept as an interval heap in one RAM.
//
//  channel | signals                    | payload
//  --------+----------------------------+------------------------------
//  request | req_valid, req_ready, req  | opcode, key
//  result  | rsp_valid, rsp_ready, rsp  | popped_key, min/max, count, status
//
// One item at a time. Clear, peek and small pops are short; inserts and larger
// pops add RAM reads for each heap level they walk on the sift-down and sift-up,
// and the single RAM read port, one read per cycle, paces them. Reset clears the
// count, the state and the result valid; the RAM is not cleared. A new item is
// taken while a finished result waits in the output register; a stalled result
// holds the sequencer at its last step.
// ----------------------------------------------------------------------------
module interval_heap_priority_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ihpq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ihpq_pkg::rsp_t rsp
);

	import ihpq_pkg::*;

	localparam int PW = CNT_W + 1;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_POPS   = 5'd2;
	localparam logic [4:0] S_POPR1  = 5'd3;
	localparam logic [4:0] S_POPR2  = 5'd4;
	localparam logic [4:0] S_SDCHK  = 5'd5;
	localparam logic [4:0] S_SDRA   = 5'd6;
	localparam logic [4:0] S_SDRB   = 5'd7;
	localparam logic [4:0] S_SUST   = 5'd8;
	localparam logic [4:0] S_SUPR   = 5'd9;
	localparam logic [4:0] S_SUMAX  = 5'd10;
	localparam logic [4:0] S_SUMAXR = 5'd11;
	localparam logic [4:0] S_SUMIN  = 5'd12;
	localparam logic [4:0] S_SUMINR = 5'd13;
	localparam logic [4:0] S_WB     = 5'd14;
	localparam logic [4:0] S_RD0    = 5'd15;
	localparam logic [4:0] S_RD1    = 5'd16;
	localparam logic [4:0] S_RD2    = 5'd17;
	localparam logic [4:0] S_FIN    = 5'd18;

	logic [4:0]       state_q, state_d;
	logic [2:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] n_q, n_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	logic [KEY_W-1:0] vpos_q, vpos_d;
	logic [KEY_W-1:0] a_q, a_d;
	logic [PW-1:0]    c_q, c_d;
	logic [KEY_W-1:0] popped_q, popped_d;
	logic [KEY_W-1:0] min_q, min_d;
	logic [KEY_W-1:0] max_q, max_d;
	logic [1:0]       status_q, status_d;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             we, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [KEY_W-1:0] wr_data, rd_data;

	logic [PW-1:0]    pos_ext, n_ext, lim, lo_ext;
	logic [IDX_W-1:0] last, partner, upper, half_m1;
	logic [CNT_W-1:0] n_m1;
	logic [PW-1:0]    sd_idx;
	logic [KEY_W-1:0] sd_val;
	logic             sd_swap, pick_a;
	logic             accept, fin_go;

	ihpq_ram #(.DEPTH(CAP), .WIDTH(KEY_W)) u_ram (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign fin_go    = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// position arithmetic
	assign pos_ext = PW'(pos_q);
	assign n_ext   = PW'(n_q);
	assign lim     = (pos_ext << 1) + (pos_q[0] ? PW'(1) : PW'(2));
	assign lo_ext  = PW'({pos_q[IDX_W-1:1], 1'b1});
	assign n_m1    = n_q - CNT_W'(1);
	assign last    = n_m1[IDX_W-1:0];
	assign partner = {pos_q[IDX_W-1:1], ~pos_q[0]};
	assign half_m1 = (pos_q >> 1) - IDX_W'(1);
	assign upper   = {half_m1[IDX_W-1:1], 1'b0};

	// pick the child to compare during sift-down
	always_comb begin
		pick_a = 1'b1;
		if (state_q == S_SDRB) begin
			pick_a = pos_q[0] ? (a_q < rd_data) : (rd_data < a_q);
		end
		sd_idx  = pick_a ? (c_q - PW'(2)) : c_q;
		sd_val  = (state_q == S_SDRB && !pick_a) ? rd_data :
		          (state_q == S_SDRB) ? a_q : rd_data;
		sd_swap = pos_q[0] ? (sd_val < vpos_q) : (vpos_q < sd_val);
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		n_d      = n_q;
		pos_d    = pos_q;
		vpos_d   = vpos_q;
		a_d      = a_q;
		c_d      = c_q;
		popped_d = popped_q;
		min_d    = min_q;
		max_d    = max_q;
		status_d = status_q;
		we       = 1'b0;
		wr_addr  = pos_q;
		wr_data  = rd_data;
		rd_en    = 1'b0;
		rd_addr  = pos_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					popped_d = '0;
					status_d = ST_OK;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_RD0;
				case (op_q)
					OP_INSERT: begin
						if (n_q >= CNT_W'(CAP)) begin
							status_d = ST_FULL;
						end else begin
							pos_d   = n_q[IDX_W-1:0];
							vpos_d  = key_q;
							n_d     = n_q + CNT_W'(1);
							state_d = S_SUST;
						end
					end
					OP_POP_MIN, OP_POP_MAX: begin
						if (n_q == '0) begin
							status_d = ST_EMPTY;
						end else if ((op_q == OP_POP_MIN && n_q < CNT_W'(3)) ||
						             (op_q == OP_POP_MAX && n_q < CNT_W'(2))) begin
							rd_en   = 1'b1;
							rd_addr = last;
							state_d = S_POPS;
						end else begin
							rd_en   = 1'b1;
							rd_addr = (op_q == OP_POP_MIN) ? IDX_W'(1) : IDX_W'(0);
							state_d = S_POPR1;
						end
					end
					OP_CLEAR: begin
						n_d = '0;
					end
					default: begin
					end
				endcase
			end
			S_POPS: begin
				popped_d = rd_data;
				n_d      = n_m1;
				state_d  = S_RD0;
			end
			S_POPR1: begin
				popped_d = rd_data;
				rd_en    = 1'b1;
				rd_addr  = last;
				state_d  = S_POPR2;
			end
			S_POPR2: begin
				vpos_d  = rd_data;
				pos_d   = (op_q == OP_POP_MIN) ? IDX_W'(1) : IDX_W'(0);
				n_d     = n_m1;
				state_d = S_SDCHK;
			end
			// sift the hole down the min or max side
			S_SDCHK: begin
				if (lim < n_ext) begin
					rd_en   = 1'b1;
					rd_addr = lim[IDX_W-1:0];
					c_d     = lim + PW'(2);
					state_d = S_SDRA;
				end else begin
					state_d = S_SUST;
				end
			end
			S_SDRA, S_SDRB: begin
				if (state_q == S_SDRA && c_q < n_ext) begin
					a_d     = rd_data;
					rd_en   = 1'b1;
					rd_addr = c_q[IDX_W-1:0];
					state_d = S_SDRB;
				end else if (sd_swap) begin
					we      = 1'b1;
					wr_addr = pos_q;
					wr_data = sd_val;
					pos_d   = sd_idx[IDX_W-1:0];
					state_d = S_SDCHK;
				end else begin
					state_d = S_SUST;
				end
			end
			// order the node pair, then climb
			S_SUST: begin
				if (lo_ext < n_ext) begin
					rd_en   = 1'b1;
					rd_addr = partner;
					state_d = S_SUPR;
				end else begin
					state_d = S_SUMAX;
				end
			end
			S_SUPR: begin
				if (pos_q[0] ? (rd_data < vpos_q) : (vpos_q < rd_data)) begin
					we      = 1'b1;
					wr_addr = pos_q;
					wr_data = rd_data;
					pos_d   = partner;
				end
				state_d = S_SUMAX;
			end
			S_SUMAX: begin
				if (pos_q > IDX_W'(1)) begin
					rd_en   = 1'b1;
					rd_addr = upper;
					state_d = S_SUMAXR;
				end else begin
					state_d = S_SUMIN;
				end
			end
			S_SUMAXR: begin
				if (rd_data >= vpos_q) begin
					state_d = S_SUMIN;
				end else begin
					we      = 1'b1;
					wr_addr = pos_q;
					wr_data = rd_data;
					pos_d   = upper;
					state_d = S_SUMAX;
				end
			end
			S_SUMIN: begin
				if (pos_q > IDX_W'(1)) begin
					rd_en   = 1'b1;
					rd_addr = {upper[IDX_W-1:1], 1'b1};
					state_d = S_SUMINR;
				end else begin
					state_d = S_WB;
				end
			end
			S_SUMINR: begin
				if (vpos_q >= rd_data) begin
					state_d = S_WB;
				end else begin
					we      = 1'b1;
					wr_addr = pos_q;
					wr_data = rd_data;
					pos_d   = {upper[IDX_W-1:1], 1'b1};
					state_d = S_SUMIN;
				end
			end
			// drop the carried key into the hole
			S_WB: begin
				we      = 1'b1;
				wr_addr = pos_q;
				wr_data = vpos_q;
				state_d = S_RD0;
			end
			// fetch the extremes
			S_RD0: begin
				if (n_q == '0) begin
					min_d   = '0;
					max_d   = '0;
					state_d = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(0);
					state_d = S_RD1;
				end
			end
			S_RD1: begin
				max_d = rd_data;
				if (n_q == CNT_W'(1)) begin
					min_d   = rd_data;
					state_d = S_FIN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(1);
					state_d = S_RD2;
				end
			end
			S_RD2: begin
				min_d   = rd_data;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			key_q <= req.key;
		end
		pos_q    <= pos_d;
		vpos_q   <= vpos_d;
		a_q      <= a_d;
		c_q      <= c_d;
		popped_q <= popped_d;
		min_q    <= min_d;
		max_q    <= max_d;
		status_q <= status_d;
		if (fin_go) begin
			rsp_q.popped_key  <= popped_q;
			rsp_q.min_key     <= min_q;
			rsp_q.max_key     <= max_q;
			rsp_q.entry_count <= n_q;
			rsp_q.status      <= status_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(CAP))
		else $error("stored count beyond capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ST_FULL |-> rsp_q.entry_count == CNT_W'(CAP))
		else $error("full status with room left");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ST_EMPTY |->
		rsp_q.entry_count == '0 && rsp_q.popped_key == '0)
		else $error("empty status on a non-empty heap");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("second item taken while busy");
`endif

endmodule

>>> bench/interval_heap_priority_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// interval_heap_priority_queue_unit_tb
// Self-checking bench for the interval heap queue: a directed table of items
// (empty pops, extreme keys, every opcode), a fill past capacity, then random
// mixes of inserts, pops and other opcodes, all checked against an in-bench
// interval heap model. Both handshakes idle at random but in the last phase.
// ----------------------------------------------------------------------------
module interval_heap_priority_queue_unit_tb;

	import ihpq_pkg::*;

	localparam int DIRECTED_N = 24;
	localparam int RANDOM_N   = 900;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// model state
	logic [KEY_W-1:0] heap_keys [CAP];
	int unsigned      heap_size;

	rsp_t expected_rsp_q[$];
	int   fail_count;
	int   rsp_count;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   full_hits;
	int   empty_hits;

	// directed table: opcode, key, check flag, expected result
	typedef struct {
		logic [2:0]       opcode;
		logic [KEY_W-1:0] key;
		bit               typed;
		rsp_t             exp;
	} dir_row_t;

	dir_row_t dir_table [DIRECTED_N];

	interval_heap_priority_queue_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void swap_keys(int unsigned a, int unsigned b);
		logic [KEY_W-1:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	function automatic int unsigned max_parent(int unsigned pos);
		return ((pos >> 1) - 1) & ~32'd1;
	endfunction

	// push a key down from pos, return where it settled
	function automatic int unsigned heap_sift_down(int unsigned pos);
		int unsigned c;
		if (pos & 1) begin
			while (2 * pos + 1 < heap_size) begin
				c = 2 * pos + 3;
				if (heap_size <= c || heap_keys[c-2] < heap_keys[c])
					c -= 2;
				if (c < heap_size && heap_keys[c] < heap_keys[pos]) begin
					swap_keys(pos, c);
					pos = c;
				end else
					break;
			end
		end else begin
			while (2 * pos + 2 < heap_size) begin
				c = 2 * pos + 4;
				if (heap_size <= c || heap_keys[c] < heap_keys[c-2])
					c -= 2;
				if (c < heap_size && heap_keys[pos] < heap_keys[c]) begin
					swap_keys(pos, c);
					pos = c;
				end else
					break;
			end
		end
		return pos;
	endfunction

	function automatic void heap_sift_up(int unsigned pos);
		int unsigned p;
		int unsigned hi;
		int unsigned lo;
		hi = pos & ~32'd1;
		lo = pos | 1;
		if (lo < heap_size && heap_keys[hi] < heap_keys[lo]) begin
			swap_keys(hi, lo);
			pos ^= 1;
		end
		while (pos > 1) begin
			p = max_parent(pos);
			if (heap_keys[p] >= heap_keys[pos])
				break;
			swap_keys(p, pos);
			pos = p;
		end
		while (pos > 1) begin
			p = max_parent(pos) | 1;
			if (heap_keys[pos] >= heap_keys[p])
				break;
			swap_keys(p, pos);
			pos = p;
		end
	endfunction

	// remove from the min (pos 1) or max (pos 0) end
	function automatic logic [KEY_W-1:0] heap_take(int unsigned root);
		int unsigned last;
		logic [KEY_W-1:0] k;
		last = heap_size - 1;
		if (heap_size < root + 2) begin
			k = heap_keys[last];
			heap_size = last;
			return k;
		end
		swap_keys(root, last);
		k = heap_keys[last];
		heap_size = last;
		heap_sift_up(heap_sift_down(root));
		return k;
	endfunction

	// apply one item to the model and return its result
	function automatic rsp_t heap_apply(req_t r);
		rsp_t o;
		o = '0;
		o.status = ST_OK;
		case (r.opcode)
			OP_INSERT: begin
				if (heap_size >= CAP)
					o.status = ST_FULL;
				else begin
					heap_keys[heap_size] = r.key;
					heap_size++;
					heap_sift_up(heap_size - 1);
				end
			end
			OP_POP_MIN, OP_POP_MAX: begin
				if (heap_size == 0)
					o.status = ST_EMPTY;
				else
					o.popped_key = heap_take(r.opcode == OP_POP_MIN ? 1 : 0);
			end
			OP_CLEAR: heap_size = 0;
			default: ;
		endcase
		if (heap_size == 1) begin
			o.min_key = heap_keys[0];
			o.max_key = heap_keys[0];
		end else if (heap_size >= 2) begin
			o.min_key = heap_keys[1];
			o.max_key = heap_keys[0];
		end
		o.entry_count = heap_size[CNT_W-1:0];
		return o;
	endfunction

	function automatic rsp_t mk_rsp(logic [KEY_W-1:0] p, logic [KEY_W-1:0] mn,
			logic [KEY_W-1:0] mx, int c, logic [1:0] s);
		rsp_t o;
		o.popped_key  = p;
		o.min_key     = mn;
		o.max_key     = mx;
		o.entry_count = c[CNT_W-1:0];
		o.status      = s;
		return o;
	endfunction

	// drive one item, hold valid until accepted
	task automatic send_item(req_t r, bit typed, rsp_t typed_exp);
		rsp_t e;
		bit   idle;
		idle = (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct);
		// drop valid only across idle cycles
		if (idle)
			req_valid <= 1'b0;
		while (idle) begin
			@(posedge clk);
			idle = (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct);
		end
		e = heap_apply(r);
		if (typed && e !== typed_exp) begin
			$error("table row disagrees with heap model: %h vs %h", typed_exp, e);
			fail_count++;
		end
		if (e.status == ST_FULL)
			full_hits++;
		if (e.status == ST_EMPTY)
			empty_hits++;
		expected_rsp_q = {expected_rsp_q, (typed ? typed_exp : e)};
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	function automatic req_t rand_req(int fill_bias);
		req_t r;
		int   pick;
		pick = $urandom_range(99);
		r.key = $urandom;
		case ($urandom_range(3))
			0: r.key = $urandom_range(15);
			1: r.key = {2'($urandom_range(3)), 30'd0} | 32'($urandom_range(7));
			default: ;
		endcase
		if (pick < fill_bias)
			r.opcode = OP_INSERT;
		else if (pick < 90)
			r.opcode = ($urandom_range(1) != 0) ? OP_POP_MIN : OP_POP_MAX;
		else if (pick < 92)
			r.opcode = OP_CLEAR;
		else
			r.opcode = 3'($urandom_range(4, 7));
		return r;
	endfunction

	task automatic wait_drained();
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// receiver: stall at random, compare each accepted result
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_count++;
				if (expected_rsp_q.size() == 0) begin
					$error("unexpected result %h", rsp);
					fail_count++;
				end else begin
					e = expected_rsp_q.pop_front();
					if (rsp.popped_key !== e.popped_key) begin
						$error("popped_key exp %h got %h", e.popped_key, rsp.popped_key);
						fail_count++;
					end
					if (rsp.min_key !== e.min_key) begin
						$error("min_key exp %h got %h", e.min_key, rsp.min_key);
						fail_count++;
					end
					if (rsp.max_key !== e.max_key) begin
						$error("max_key exp %h got %h", e.max_key, rsp.max_key);
						fail_count++;
					end
					if (rsp.entry_count !== e.entry_count) begin
						$error("entry_count exp %0d got %0d", e.entry_count,
							rsp.entry_count);
						fail_count++;
					end
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status);
						fail_count++;
					end
				end
			end
			rsp_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// run limit
	initial begin
		#60_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		req_t r;
		int   bias;
		logic [KEY_W-1:0] kmax;
		kmax = '1;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		fail_count = 0;
		rsp_count = 0;
		full_hits = 0;
		empty_hits = 0;
		heap_size = 0;
		send_idle_pct = 34;
		recv_idle_pct = 48;

		// directed table: empty pops, extremes, every opcode
		dir_table[0]  = '{OP_POP_MIN, '0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY)};
		dir_table[1]  = '{OP_POP_MAX, '1, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY)};
		dir_table[2]  = '{OP_PEEK, '1, 1, mk_rsp(0, 0, 0, 0, ST_OK)};
		dir_table[3]  = '{OP_INSERT, kmax, 1, mk_rsp(0, kmax, kmax, 1, ST_OK)};
		dir_table[4]  = '{OP_INSERT, '0, 1, mk_rsp(0, 0, kmax, 2, ST_OK)};
		dir_table[5]  = '{OP_INSERT, 32'h5555_AAAA, 0, '0};
		dir_table[6]  = '{OP_INSERT, 32'hAAAA_5555, 0, '0};
		dir_table[7]  = '{3'd5, '0, 1, mk_rsp(0, 0, kmax, 4, ST_OK)};
		dir_table[8]  = '{3'd6, '1, 0, '0};
		dir_table[9]  = '{3'd7, 32'h1234_5678, 0, '0};
		dir_table[10] = '{OP_POP_MAX, '0, 0, '0};
		dir_table[11] = '{OP_POP_MIN, '0, 0, '0};
		dir_table[12] = '{OP_INSERT, 32'd7, 0, '0};
		dir_table[13] = '{OP_INSERT, 32'd7, 0, '0};
		dir_table[14] = '{OP_POP_MIN, '0, 0, '0};
		dir_table[15] = '{OP_POP_MAX, '0, 0, '0};
		dir_table[16] = '{OP_POP_MAX, '0, 0, '0};
		dir_table[17] = '{OP_POP_MIN, '0, 0, '0};
		dir_table[18] = '{OP_INSERT, 32'd3, 0, '0};
		dir_table[19] = '{OP_INSERT, 32'd9, 0, '0};
		dir_table[20] = '{OP_CLEAR, '0, 1, mk_rsp(0, 0, 0, 0, ST_OK)};
		dir_table[21] = '{OP_POP_MAX, '0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY)};
		dir_table[22] = '{OP_INSERT, 32'h8000_0000, 0, '0};
		dir_table[23] = '{OP_POP_MAX, '0, 1,
			mk_rsp(32'h8000_0000, 0, 0, 0, ST_OK)};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			r.opcode = dir_table[i].opcode;
			r.key    = dir_table[i].key;
			send_item(r, dir_table[i].typed, dir_table[i].exp);
		end

		// fill to capacity and beyond to reach the full status
		for (int i = 0; i < CAP + 3; i++) begin
			r.opcode = OP_INSERT;
			r.key = ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(3));
			send_item(r, 0, '0);
		end
		r.opcode = OP_CLEAR;
		send_item(r, 0, '0);

		// random phases: swap idling, then none
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 48;
				recv_idle_pct = 34;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < RANDOM_N / 3; i++) begin
				// alternate between growing and shrinking the heap
				bias = ((i / 80) % 2 == 0) ? 70 : 25;
				send_item(rand_req(bias), 0, '0);
			end
		end
		req_valid <= 1'b0;

		// final settle
		begin
			int waited;
			waited = 0;
			while (expected_rsp_q.size() != 0 && waited < 100_000) begin
				@(posedge clk);
				waited++;
			end
		end
		wait_drained();

		$display("covered %0d results, %0d full inserts, %0d empty pops",
			rsp_count, full_hits, empty_hits);
		if (fail_count == 0 && expected_rsp_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
